@@ design/lif_pkg.sv @@
// lif_pkg: shared types, register codes and helpers for the lif neuron core.
// No dependencies; used by lif_ctrl, lif_datapath and lif_neuron_core.

package lif_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_REST_VOLTAGE      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESET_VOLTAGE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD_VOLTAGE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEMBRANE_RES      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LEAK_COEFF        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP         = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_REFRACTORY_PERIOD = 3'd6;
  localparam int unsigned CfgDataW = 24;

  // register reset values
  localparam logic [23:0] REST_VOLTAGE_RST      = 24'd0;
  localparam logic [23:0] RESET_VOLTAGE_RST     = 24'd0;
  localparam logic [23:0] THRESHOLD_VOLTAGE_RST = 24'd256;
  localparam logic [15:0] MEMBRANE_RES_RST      = 16'd256;
  localparam logic [15:0] LEAK_COEFF_RST        = 16'd0;
  localparam logic [15:0] TIME_STEP_RST         = 16'd1;
  localparam logic [15:0] REFRACTORY_PERIOD_RST = 16'd0;

  // item commands
  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_SYNAPSE = 1'b1;

  localparam logic signed [23:0] V_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] V_MIN = -24'sh800000;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         neuron_index;
    logic signed [23:0] input_current;
    logic [31:0]        sim_time;
    logic [9:0]         source_index;
    logic [9:0]         target_index;
    logic signed [23:0] synapse_weight;
    logic               batch_last;
  } lif_in_t;

  typedef struct packed {
    logic               spiked;
    logic signed [23:0] membrane_voltage;
    logic [31:0]        spike_total;
    logic [31:0]        last_spike;
    logic               delivered;
    logic               batch_done;
  } lif_out_t;

  // one neuron record as held in the state memory
  typedef struct packed {
    logic signed [23:0] voltage;
    logic [15:0]        refractory;
    logic [31:0]        spike_time;
    logic [31:0]        spike_tally;
  } lif_rec_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // transaction accepted, memories read
    logic capture;    // memory data in, first product
    logic multiply;   // leak product
    logic commit;     // write back and load result register
    logic clear_step; // clearing pass, one entry
  } lif_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_synapse;
    logic clear_last;
    logic out_free;
  } lif_status_t;

  // saturate a wide signed sum to a Q16.8 voltage
  function automatic logic signed [23:0] sat_v(input logic signed [35:0] x);
    logic signed [23:0] r;
    if (x > 36'(V_MAX)) begin
      r = V_MAX;
    end else if (x < 36'(V_MIN)) begin
      r = V_MIN;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

@@ design/lif_ram.sv @@
// lif_ram: generic single write, single read RAM with registered read data.
// No dependencies.

module lif_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lif_ctrl.sv @@
// lif_ctrl: sequencing state machine of the lif neuron core.
// Depends on lif_pkg for the command and status structs.

module lif_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lif_pkg::lif_status_t status_i,
  output lif_pkg::lif_cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MEM   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MEM;
        end
      end
      ST_MEM: begin
        cmd_o.capture = 1'b1;
        state_d       = status_i.is_synapse ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.multiply = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register can take the result
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/lif_datapath.sv @@
// lif_datapath: configuration registers, neuron state memories, fixed point
// integration and the result register. Depends on lif_pkg and lif_ram.

module lif_datapath #(
  parameter int unsigned NEURON_COUNT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lif_pkg::lif_cmd_t              cmd_i,
  output lif_pkg::lif_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [lif_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lif_pkg::CfgDataW-1:0]   cfg_data_i,
  input  lif_pkg::lif_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lif_pkg::lif_out_t              out_data_o
);

  localparam int unsigned AddrW = $clog2(NEURON_COUNT);
  localparam int unsigned RecW  = $bits(lif_pkg::lif_rec_t);
  localparam logic [31:0] NCount = 32'(NEURON_COUNT);

  // configuration registers
  logic signed [23:0] rest_q, reset_v_q, thresh_q;
  logic [15:0]        rm_q, leak_q, tstep_q, refr_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q        <= lif_pkg::REST_VOLTAGE_RST;
      reset_v_q     <= lif_pkg::RESET_VOLTAGE_RST;
      thresh_q      <= lif_pkg::THRESHOLD_VOLTAGE_RST;
      rm_q          <= lif_pkg::MEMBRANE_RES_RST;
      leak_q        <= lif_pkg::LEAK_COEFF_RST;
      tstep_q       <= lif_pkg::TIME_STEP_RST;
      refr_period_q <= lif_pkg::REFRACTORY_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lif_pkg::CFG_REST_VOLTAGE:      rest_q        <= cfg_data_i;
        lif_pkg::CFG_RESET_VOLTAGE:     reset_v_q     <= cfg_data_i;
        lif_pkg::CFG_THRESHOLD_VOLTAGE: thresh_q      <= cfg_data_i;
        lif_pkg::CFG_MEMBRANE_RES:      rm_q          <= cfg_data_i[15:0];
        lif_pkg::CFG_LEAK_COEFF:        leak_q        <= cfg_data_i[15:0];
        lif_pkg::CFG_TIME_STEP:         tstep_q       <= cfg_data_i[15:0];
        lif_pkg::CFG_REFRACTORY_PERIOD: refr_period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  // latched transaction
  lif_pkg::lif_in_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  // memories: read addresses come straight from the accepted transaction
  logic [AddrW-1:0] rec_raddr, flag_raddr, waddr;
  logic             rec_we, flag_we, flag_wdata, flag_rdata;
  logic [RecW-1:0]  rec_wdata, rec_rdata;

  assign rec_raddr  = (in_data_i.cmd == lif_pkg::CMD_SYNAPSE) ?
                      AddrW'(in_data_i.target_index) : AddrW'(in_data_i.neuron_index);
  assign flag_raddr = (in_data_i.cmd == lif_pkg::CMD_SYNAPSE) ?
                      AddrW'(in_data_i.source_index) : AddrW'(in_data_i.neuron_index);

  lif_ram #(
    .Width(RecW),
    .Depth(NEURON_COUNT)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (rec_we),
    .waddr_i(waddr),
    .wdata_i(rec_wdata),
    .raddr_i(rec_raddr),
    .rdata_o(rec_rdata)
  );

  lif_ram #(
    .Width(1),
    .Depth(NEURON_COUNT)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .waddr_i(waddr),
    .wdata_i(flag_wdata),
    .raddr_i(flag_raddr),
    .rdata_o(flag_rdata)
  );

  // capture stage: memory data and drive product r_m * I
  lif_pkg::lif_rec_t  rec_q;
  logic               flag_q;
  logic signed [40:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rec_q  <= lif_pkg::lif_rec_t'(rec_rdata);
      flag_q <= flag_rdata;
      prod_q <= $signed({1'b0, rm_q}) * $signed(item_q.input_current);
    end
  end

  // leak stage: dv = floor(k * (drive - (v - v_rest)) / 2^16)
  logic signed [32:0] drive;
  logic signed [24:0] diff;
  logic signed [33:0] sum;
  logic signed [50:0] dv_full;
  logic signed [34:0] dv_q;

  assign drive   = prod_q[40:8];
  assign diff    = $signed({rec_q.voltage[23], rec_q.voltage}) - $signed({rest_q[23], rest_q});
  assign sum     = $signed({drive[32], drive}) - $signed({{9{diff[24]}}, diff});
  assign dv_full = $signed({1'b0, leak_q}) * sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.multiply) begin
      dv_q <= dv_full[50:16];
    end
  end

  // final stage: new voltage, firing, synapse add
  logic signed [23:0] v_int, v_syn;
  logic               fire, n_in_range, src_in_range, dst_in_range, deliver;
  logic [15:0]        refr_dec;
  logic               wr_en, flag_new;
  lif_pkg::lif_rec_t  rec_new;
  lif_pkg::lif_out_t  res;

  assign v_int = lif_pkg::sat_v($signed({{12{rec_q.voltage[23]}}, rec_q.voltage})
                                + $signed({dv_q[34], dv_q}));
  assign v_syn = lif_pkg::sat_v($signed({{12{rec_q.voltage[23]}}, rec_q.voltage})
                                + $signed({{12{item_q.synapse_weight[23]}},
                                           item_q.synapse_weight}));
  assign fire         = (v_int >= thresh_q);
  assign refr_dec     = (rec_q.refractory >= tstep_q) ? (rec_q.refractory - tstep_q) : 16'd0;
  assign n_in_range   = (32'(item_q.neuron_index) < NCount);
  assign src_in_range = (32'(item_q.source_index) < NCount);
  assign dst_in_range = (32'(item_q.target_index) < NCount);
  assign deliver      = src_in_range && flag_q;

  always_comb begin
    rec_new        = rec_q;
    flag_new       = 1'b0;
    wr_en          = 1'b0;
    res            = '0;
    res.batch_done = item_q.batch_last;
    if (item_q.cmd == lif_pkg::CMD_UPDATE) begin
      if (n_in_range) begin
        wr_en = 1'b1;
        if (rec_q.refractory != 16'd0) begin
          // refractory: count down and hold at the reset voltage
          rec_new.voltage    = reset_v_q;
          rec_new.refractory = refr_dec;
        end else if (fire) begin
          rec_new.voltage     = reset_v_q;
          rec_new.spike_time  = item_q.sim_time;
          rec_new.refractory  = refr_period_q;
          rec_new.spike_tally = rec_q.spike_tally + 32'd1;
          flag_new            = 1'b1;
        end else begin
          rec_new.voltage = v_int;
        end
        res.spiked           = flag_new;
        res.membrane_voltage = rec_new.voltage;
        res.spike_total      = rec_new.spike_tally;
        res.last_spike       = rec_new.spike_time;
      end
    end else if (dst_in_range) begin
      if (deliver) begin
        wr_en           = 1'b1;
        rec_new.voltage = v_syn;
        res.delivered   = 1'b1;
      end
      res.membrane_voltage = rec_new.voltage;
    end
  end

  // write port: clearing pass or write back
  assign waddr      = cmd_i.clear_step ? clr_cnt_q :
                      (item_q.cmd == lif_pkg::CMD_SYNAPSE) ? AddrW'(item_q.target_index) :
                                                             AddrW'(item_q.neuron_index);
  assign rec_we     = cmd_i.clear_step || (cmd_i.commit && wr_en);
  assign flag_we    = cmd_i.clear_step ||
                      (cmd_i.commit && wr_en && (item_q.cmd == lif_pkg::CMD_UPDATE));
  assign rec_wdata  = cmd_i.clear_step ? '0 : RecW'(rec_new);
  assign flag_wdata = cmd_i.clear_step ? 1'b0 : flag_new;

  // result register
  logic              out_valid_q, out_valid_d;
  lif_pkg::lif_out_t out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status to the controller
  assign status_o.is_synapse = (item_q.cmd == lif_pkg::CMD_SYNAPSE);
  assign status_o.clear_last = (clr_cnt_q == AddrW'(NEURON_COUNT - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ design/lif_neuron_core.sv @@
// lif_neuron_core: top level of the leaky integrate-and-fire neuron store.
// Depends on lif_pkg, lif_ctrl, lif_datapath (and lif_ram through it).
//
// Usage:
// - input channel (in_valid_i/in_ready_o/in_data_i): one transaction per
//   item, either a neuron update (cmd 0) or a synapse delivery (cmd 1)
// - output channel (out_valid_o/out_ready_i/out_data_o): exactly one result
//   transaction per item, in order
// - configuration port: cfg_we_i writes cfg_data_i into register
//   cfg_index_i; write only while no item is in flight
// - an update goes from acceptance through the registered read of the neuron
//   memory and the two multiply stages (r_m * I, then k * sum) to its final
//   stage before the next acceptance; a synapse item skips the k * sum stage
// - the result appears in the output register on the cycle after the
//   final stage; a new item may be accepted while it waits to be taken
// - if the receiver stalls with a result still held, the next item stops
//   in its final stage until the register frees up
// - after reset a clearing pass zeroes the neuron memories, one entry per
//   cycle, with in_ready_o low until the last entry; configuration writes
//   are taken during it

module lif_neuron_core #(
  parameter int unsigned NEURON_COUNT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lif_pkg::lif_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lif_pkg::lif_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lif_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lif_pkg::CfgDataW-1:0] cfg_data_i
);

  lif_pkg::lif_cmd_t    ctrl_cmd;
  lif_pkg::lif_status_t dp_status;

  // sequencing
  lif_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  // arithmetic and state
  lif_datapath #(
    .NEURON_COUNT(NEURON_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .status_o   (dp_status),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // a result is only committed when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("result committed over a pending result");

  // one item in flight: no acceptance in the cycle after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  // no transaction accepted during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.clear_step |-> !in_ready_o)
    else $error("input ready during clearing pass");

  // every commit yields a valid result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

endmodule
